// File: sv/round_robin_slice_scheduler_macros.svh
// Assertion macros used by the scheduler engine, rrss_engine.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_MACROS_SVH

// Checks cons in the same cycle as ante.
`define RRSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrss: same-cycle check failed");

// Checks cons in the cycle after ante.
`define RRSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrss: next-cycle check failed");

`endif

// File: sv/rrss_pkg.sv
`timescale 1ns / 1ps

package rrss_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int TIME_WIDTH    = 16;

  localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int QNT_W   = 16;
  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int CLK_W   = 20;
  localparam int CMP_W   = (TIME_WIDTH > QNT_W) ? TIME_WIDTH : QNT_W;

  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_WIDTH) - 64'd1;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CNT_W:0]        cnt_sum_t;
  typedef logic [TIME_WIDTH-1:0] rem_t;
  typedef logic [QNT_W-1:0]      qnt_t;
  typedef logic [ID_W-1:0]       pid_t;
  typedef logic [BURST_W-1:0]    burst_t;
  typedef logic [CLK_W-1:0]      clk_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [1:0]            cmd_t;
  typedef logic [2:0]            status_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_STEP  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam status_t ST_LOADED  = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_ISSUED  = 3'd2;
  localparam status_t ST_NO_WORK = 3'd3;
  localparam status_t ST_CLEARED = 3'd4;

  localparam qnt_t QUANTUM_RESET = 16'd3;

  typedef struct packed {
    status_t status;
    pid_t    process_id;
    qnt_t    length;
    clk_t    start;
    logic    finishes;
  } result_t;

endpackage

// File: sv/rrss_engine.sv
`timescale 1ns / 1ps

module rrss_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               do_op,
  input  rrss_pkg::cmd_t     command,
  input  rrss_pkg::pid_t     process_id,
  input  rrss_pkg::burst_t   burst_time,
  input  rrss_pkg::qnt_t     quantum,
  output rrss_pkg::result_t  result
);

  rrss_pkg::slot_t fifo_mem_r [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::rem_t  rem_mem_r  [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::pid_t  id_mem_r   [rrss_pkg::MAX_PROCESSES];

  rrss_pkg::slot_t fifo_head_r, fifo_head_nxt;
  rrss_pkg::cnt_t  fifo_count_r, fifo_count_nxt;
  rrss_pkg::cnt_t  loaded_count_r, loaded_count_nxt;
  rrss_pkg::clk_t  cur_time_r, cur_time_nxt;

  rrss_pkg::qnt_t     q_eff;
  rrss_pkg::slot_t    head_slot;
  rrss_pkg::rem_t     head_rem;
  rrss_pkg::cmp_t     rem_ext;
  rrss_pkg::cmp_t     q_ext;
  rrss_pkg::qnt_t     grant;
  rrss_pkg::rem_t     rem_new;
  rrss_pkg::rem_t     burst_sat;
  rrss_pkg::cnt_sum_t tail_sum;
  rrss_pkg::slot_t    tail_idx;
  rrss_pkg::slot_t    head_inc;
  rrss_pkg::slot_t    load_slot;
  logic               table_full;
  logic               step_issue;

  logic            fifo_we;
  rrss_pkg::slot_t fifo_wdata;
  logic            rem_we;
  rrss_pkg::slot_t rem_waddr;
  rrss_pkg::rem_t  rem_wdata;
  logic            id_we;

  always_comb begin
    q_eff     = (quantum == '0) ? rrss_pkg::qnt_t'(1) : quantum;
    head_slot = fifo_mem_r[fifo_head_r];
    head_rem  = rem_mem_r[head_slot];
    rem_ext   = rrss_pkg::cmp_t'(head_rem);
    q_ext     = rrss_pkg::cmp_t'(q_eff);
    grant     = (rem_ext < q_ext) ? rrss_pkg::qnt_t'(rem_ext) : q_eff;
    rem_new   = rrss_pkg::rem_t'(rem_ext - rrss_pkg::cmp_t'(grant));
    if (rrss_pkg::cmp_t'(burst_time) > rrss_pkg::cmp_t'(rrss_pkg::TIME_MAX)) begin
      burst_sat = rrss_pkg::rem_t'(rrss_pkg::TIME_MAX);
    end else begin
      burst_sat = rrss_pkg::rem_t'(burst_time);
    end
    // The tail position is the same for a load and for a requeue after a pop.
    tail_sum = rrss_pkg::cnt_sum_t'(fifo_head_r) + rrss_pkg::cnt_sum_t'(fifo_count_r);
    if (tail_sum >= rrss_pkg::cnt_sum_t'(rrss_pkg::MAX_PROCESSES)) begin
      tail_idx = rrss_pkg::slot_t'(tail_sum - rrss_pkg::cnt_sum_t'(rrss_pkg::MAX_PROCESSES));
    end else begin
      tail_idx = rrss_pkg::slot_t'(tail_sum);
    end
    if (fifo_head_r == rrss_pkg::slot_t'(rrss_pkg::MAX_PROCESSES - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = fifo_head_r + rrss_pkg::slot_t'(1);
    end
    load_slot  = rrss_pkg::slot_t'(loaded_count_r);
    table_full = (loaded_count_r == rrss_pkg::cnt_t'(rrss_pkg::MAX_PROCESSES));
    step_issue = do_op && (command == rrss_pkg::CMD_STEP) && (fifo_count_r != '0);
  end

  always_comb begin
    fifo_head_nxt    = fifo_head_r;
    fifo_count_nxt   = fifo_count_r;
    loaded_count_nxt = loaded_count_r;
    cur_time_nxt     = cur_time_r;
    fifo_we          = 1'b0;
    fifo_wdata       = load_slot;
    rem_we           = 1'b0;
    rem_waddr        = load_slot;
    rem_wdata        = burst_sat;
    id_we            = 1'b0;
    result           = '0;
    result.status    = rrss_pkg::ST_NO_WORK;
    if (do_op) begin
      unique case (command)
        rrss_pkg::CMD_LOAD: begin
          if (table_full) begin
            result.status = rrss_pkg::ST_FULL;
          end else begin
            id_we            = 1'b1;
            rem_we           = 1'b1;
            fifo_we          = 1'b1;
            loaded_count_nxt = loaded_count_r + rrss_pkg::cnt_t'(1);
            fifo_count_nxt   = fifo_count_r + rrss_pkg::cnt_t'(1);
            result.status    = rrss_pkg::ST_LOADED;
          end
        end
        rrss_pkg::CMD_STEP: begin
          if (fifo_count_r != '0) begin
            fifo_head_nxt     = head_inc;
            rem_we            = 1'b1;
            rem_waddr         = head_slot;
            rem_wdata         = rem_new;
            cur_time_nxt      = cur_time_r + rrss_pkg::clk_t'(grant);
            result.status     = rrss_pkg::ST_ISSUED;
            result.process_id = id_mem_r[head_slot];
            result.length     = grant;
            result.start      = cur_time_r;
            result.finishes   = (rem_new == '0);
            if (rem_new != '0) begin
              fifo_we    = 1'b1;
              fifo_wdata = head_slot;
            end else begin
              fifo_count_nxt = fifo_count_r - rrss_pkg::cnt_t'(1);
            end
          end
        end
        rrss_pkg::CMD_CLEAR: begin
          fifo_head_nxt    = '0;
          fifo_count_nxt   = '0;
          loaded_count_nxt = '0;
          cur_time_nxt     = '0;
          result.status    = rrss_pkg::ST_CLEARED;
        end
        default: begin
          result.status = rrss_pkg::ST_NO_WORK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_head_r    <= '0;
      fifo_count_r   <= '0;
      loaded_count_r <= '0;
      cur_time_r     <= '0;
    end else begin
      fifo_head_r    <= fifo_head_nxt;
      fifo_count_r   <= fifo_count_nxt;
      loaded_count_r <= loaded_count_nxt;
      cur_time_r     <= cur_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem_r[tail_idx] <= fifo_wdata;
    end
    if (rem_we) begin
      rem_mem_r[rem_waddr] <= rem_wdata;
    end
    if (id_we) begin
      id_mem_r[load_slot] <= process_id;
    end
  end

  `include "round_robin_slice_scheduler_macros.svh"

  `RRSS_ASSERT_NOW(a_queue_within_loaded, 1'b1, fifo_count_r <= loaded_count_r)
  `RRSS_ASSERT_NOW(a_loaded_bounded, 1'b1,
    loaded_count_r <= rrss_pkg::cnt_t'(rrss_pkg::MAX_PROCESSES))
  `RRSS_ASSERT_NEXT(a_requeue_keeps_count, step_issue && (rem_new != '0),
    fifo_count_r == $past(fifo_count_r))
  `RRSS_ASSERT_NEXT(a_time_advances, step_issue,
    cur_time_r == ($past(cur_time_r) + rrss_pkg::clk_t'($past(grant))))

endmodule

// File: sv/round_robin_slice_scheduler.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   command, process_id, burst_time
// out_     output     out_valid/out_stall status, slice_process_id, slice_length,
//                                         slice_start, slice_finishes
// cfg_     input      cfg_valid/cfg_ready time_quantum
//
// One request is taken per cycle while out_stall does not hold a waiting result; each is
// held in the input register, and its result is registered in the output register.
// rst_n is synchronous and active low; it clears the queue, the counters and the time
// and sets the quantum to 3. The tables need no clearing pass.
// While out_stall holds a waiting result, one further request is held in the input
// register, and in_stall rises after that.

module round_robin_slice_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_burst_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_slice_process_id,
  output logic [15:0] out_slice_length,
  output logic [19:0] out_slice_start,
  output logic        out_slice_finishes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_time_quantum
);

  logic               s1_valid_r;
  rrss_pkg::cmd_t     s1_cmd_r;
  rrss_pkg::pid_t     s1_pid_r;
  rrss_pkg::burst_t   s1_burst_r;
  logic               out_valid_r;
  rrss_pkg::result_t  out_res_r;
  rrss_pkg::qnt_t     quantum_r;
  rrss_pkg::result_t  eng_res;
  logic               adv_out;
  logic               do_op;
  logic               load_s1;

  assign adv_out  = !out_valid_r || !out_stall;
  assign do_op    = s1_valid_r && adv_out;
  assign in_stall = s1_valid_r && !adv_out;
  assign load_s1  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  rrss_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .do_op      (do_op),
    .command    (s1_cmd_r),
    .process_id (s1_pid_r),
    .burst_time (s1_burst_r),
    .quantum    (quantum_r),
    .result     (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      quantum_r   <= rrss_pkg::QUANTUM_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_time_quantum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_cmd_r   <= in_command;
      s1_pid_r   <= in_process_id;
      s1_burst_r <= in_burst_time;
    end
    if (do_op) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_slice_process_id = out_res_r.process_id;
  assign out_slice_length     = out_res_r.length;
  assign out_slice_start      = out_res_r.start;
  assign out_slice_finishes   = out_res_r.finishes;

endmodule

// File: bench/slice_grant_checker.sv
`timescale 1ns / 1ps

module slice_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_burst_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_slice_process_id,
  input  logic [15:0] out_slice_length,
  input  logic [19:0] out_slice_start,
  input  logic        out_slice_finishes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_time_quantum,
  output int unsigned pending_grants,
  output int unsigned fail_count
);

  rrss_pkg::qnt_t    sched_quantum;
  rrss_pkg::slot_t   wait_ring [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::slot_t   ring_head;
  rrss_pkg::cnt_t    ring_fill;
  rrss_pkg::rem_t    time_left [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::pid_t    owner_id  [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::cnt_t    slots_used;
  rrss_pkg::clk_t    clock_now;
  rrss_pkg::result_t awaited_grants [$];
  int unsigned       mismatches = 0;

  function automatic void wipe_schedule();
    for (int i = 0; i < rrss_pkg::MAX_PROCESSES; i++) begin
      wait_ring[i] = '0;
      time_left[i] = '0;
      owner_id[i] = '0;
    end
    ring_head = '0;
    ring_fill = '0;
    slots_used = '0;
    clock_now = '0;
  endfunction

  function automatic void enqueue_slot(rrss_pkg::slot_t slot);
    wait_ring[rrss_pkg::slot_t'((ring_head + ring_fill) % rrss_pkg::MAX_PROCESSES)] = slot;
    ring_fill = ring_fill + 1'b1;
  endfunction

  function automatic rrss_pkg::result_t grant_for_request(rrss_pkg::cmd_t cmd,
                                                          rrss_pkg::pid_t pid,
                                                          rrss_pkg::burst_t burst);
    rrss_pkg::result_t r;
    rrss_pkg::slot_t   slot;
    rrss_pkg::rem_t    left;
    rrss_pkg::cmp_t    q;
    rrss_pkg::cmp_t    grant;
    r = '0;
    case (cmd)
      rrss_pkg::CMD_LOAD: begin
        if (slots_used >= rrss_pkg::MAX_PROCESSES) begin
          r.status = rrss_pkg::ST_FULL;
        end else begin
          slot = rrss_pkg::slot_t'(slots_used);
          owner_id[slot] = pid;
          time_left[slot] = (burst > rrss_pkg::TIME_MAX) ?
                            rrss_pkg::rem_t'(rrss_pkg::TIME_MAX) : rrss_pkg::rem_t'(burst);
          slots_used = slots_used + 1'b1;
          enqueue_slot(slot);
          r.status = rrss_pkg::ST_LOADED;
        end
      end
      rrss_pkg::CMD_STEP: begin
        if (ring_fill == 0) begin
          r.status = rrss_pkg::ST_NO_WORK;
        end else begin
          slot = wait_ring[ring_head];
          left = time_left[slot];
          q = (sched_quantum == 0) ? rrss_pkg::cmp_t'(1) : rrss_pkg::cmp_t'(sched_quantum);
          grant = (rrss_pkg::cmp_t'(left) < q) ? rrss_pkg::cmp_t'(left) : q;
          ring_head = rrss_pkg::slot_t'((ring_head + 1) % rrss_pkg::MAX_PROCESSES);
          ring_fill = ring_fill - 1'b1;
          left = rrss_pkg::rem_t'(left - grant);
          time_left[slot] = left;
          r.status = rrss_pkg::ST_ISSUED;
          r.process_id = owner_id[slot];
          r.length = rrss_pkg::qnt_t'(grant);
          r.start = clock_now;
          r.finishes = (left == 0);
          clock_now = rrss_pkg::clk_t'(clock_now + grant);
          if (left != 0) begin
            enqueue_slot(slot);
          end
        end
      end
      rrss_pkg::CMD_CLEAR: begin
        wipe_schedule();
        r.status = rrss_pkg::ST_CLEARED;
      end
      default: begin
        r.status = rrss_pkg::ST_NO_WORK;
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rrss_pkg::result_t want;
    rrss_pkg::result_t fresh;
    if (!rst_n) begin
      sched_quantum = rrss_pkg::QUANTUM_RESET;
      wipe_schedule();
      awaited_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        sched_quantum = cfg_time_quantum;
      end
      if (out_valid && !out_stall) begin
        if (awaited_grants.size() == 0) begin
          $error("result with status %0d arrived with no request waiting", out_status);
          mismatches++;
        end else begin
          want = awaited_grants.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("slice_process_id", want.process_id, out_slice_process_id);
          compare_field("slice_length", want.length, out_slice_length);
          compare_field("slice_start", want.start, out_slice_start);
          compare_field("slice_finishes", want.finishes, out_slice_finishes);
        end
      end
      if (in_valid && !in_stall) begin
        fresh = grant_for_request(in_command, in_process_id, in_burst_time);
        awaited_grants.insert(awaited_grants.size(), fresh);
      end
    end
    pending_grants <= awaited_grants.size();
    fail_count <= mismatches;
  end

endmodule

// File: bench/tb_round_robin_slice_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_slice_scheduler;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SEGMENT_REQUESTS = 190;
  localparam rrss_pkg::cmd_t CMD_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [15:0] in_process_id;
  logic [15:0] in_burst_time;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_slice_process_id;
  logic [15:0] out_slice_length;
  logic [19:0] out_slice_start;
  logic        out_slice_finishes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_time_quantum;
  int unsigned pending_grants;
  int unsigned fail_count;

  int unsigned    send_idle = 38;
  int unsigned    recv_idle = 65;
  int unsigned    quiet_cycles = 0;
  int unsigned    sent = 0;
  int unsigned    loaded_now = 0;
  longint         slices_left = 0;
  rrss_pkg::qnt_t quantum_now = rrss_pkg::QUANTUM_RESET;

  round_robin_slice_scheduler dut (.*);

  slice_grant_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_round_robin_slice_scheduler NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint effective_quantum();
    return (quantum_now == 0) ? 1 : quantum_now;
  endfunction

  function automatic rrss_pkg::burst_t pick_burst();
    longint cap;
    if ($urandom_range(15) == 0) begin
      return '0;
    end
    cap = effective_quantum() * $urandom_range(1, 4);
    if (cap > 65535) begin
      cap = 65535;
    end
    return rrss_pkg::burst_t'($urandom_range(0, int'(cap)));
  endfunction

  task automatic issue(rrss_pkg::cmd_t cmd, rrss_pkg::pid_t pid, rrss_pkg::burst_t burst);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_process_id = pid;
    in_burst_time = burst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd == rrss_pkg::CMD_LOAD && loaded_now < rrss_pkg::MAX_PROCESSES) begin
      loaded_now++;
      slices_left += (burst == 0) ? 1 : (burst + effective_quantum() - 1) / effective_quantum();
    end else if (cmd == rrss_pkg::CMD_STEP && slices_left > 0) begin
      slices_left--;
    end else if (cmd == rrss_pkg::CMD_CLEAR) begin
      loaded_now = 0;
      slices_left = 0;
    end
    sent++;
  endtask

  task automatic issue_step();
    issue(rrss_pkg::CMD_STEP, rrss_pkg::pid_t'($urandom), rrss_pkg::burst_t'($urandom));
  endtask

  task automatic issue_clear();
    issue(rrss_pkg::CMD_CLEAR, rrss_pkg::pid_t'($urandom), rrss_pkg::burst_t'($urandom));
  endtask

  task automatic set_quantum(rrss_pkg::qnt_t value);
    in_valid = 1'b0;
    while (pending_grants != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_time_quantum = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    quantum_now = value;
  endtask

  task automatic run_segment(int unsigned quota);
    int unsigned first;
    int unsigned loads;
    first = sent;
    while (sent - first < quota) begin
      if ($urandom_range(99) < 80) begin
        if (loaded_now >= 12) begin
          issue_clear();
        end
        loads = ($urandom_range(7) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
        repeat (loads) begin
          issue(rrss_pkg::CMD_LOAD, rrss_pkg::pid_t'($urandom), pick_burst());
          if ($urandom_range(4) == 0) begin
            issue_step();
          end
        end
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(0, int'(slices_left))) issue_step();
          issue_clear();
        end else begin
          while (slices_left > 0) issue_step();
          repeat ($urandom_range(0, 2)) issue_step();
        end
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: issue(rrss_pkg::CMD_LOAD, rrss_pkg::pid_t'($urandom), pick_burst());
          7: issue_clear();
          8: issue(CMD_UNKNOWN, rrss_pkg::pid_t'($urandom), rrss_pkg::burst_t'($urandom));
          default: issue_step();
        endcase
      end
    end
  endtask

  initial begin
    rrss_pkg::qnt_t quanta [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = rrss_pkg::CMD_LOAD;
    in_process_id = '0;
    in_burst_time = '0;
    cfg_valid = 1'b0;
    cfg_time_quantum = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue_step();
    issue(CMD_UNKNOWN, 16'hffff, 16'hffff);
    issue(rrss_pkg::CMD_LOAD, 16'h0000, 16'h0000);
    issue(rrss_pkg::CMD_LOAD, 16'hffff, 16'hffff);
    issue(rrss_pkg::CMD_LOAD, 16'h1234, 16'h0005);
    repeat (3) issue_step();
    issue_clear();
    for (int i = 0; i <= rrss_pkg::MAX_PROCESSES; i++) begin
      issue(rrss_pkg::CMD_LOAD, rrss_pkg::pid_t'(16'h0100 + i), rrss_pkg::burst_t'(i));
    end

    quanta[0] = 16'hffff;
    quanta[1] = 16'd1;
    quanta[2] = 16'd0;
    quanta[3] = rrss_pkg::qnt_t'($urandom_range(2, 50));
    quanta[4] = rrss_pkg::qnt_t'($urandom_range(51, 65534));
    quanta[5] = rrss_pkg::QUANTUM_RESET;
    for (int seg = 0; seg < 6; seg++) begin
      send_idle = (seg < 2) ? 38 : (seg < 4) ? 65 : 0;
      recv_idle = (seg < 2) ? 65 : (seg < 4) ? 38 : 0;
      issue_clear();
      set_quantum(quanta[seg]);
      if (seg == 0) begin
        repeat (rrss_pkg::MAX_PROCESSES) begin
          issue(rrss_pkg::CMD_LOAD, rrss_pkg::pid_t'($urandom), 16'hffff);
        end
        while (slices_left > 0) issue_step();
      end
      run_segment(SEGMENT_REQUESTS);
    end

    in_valid = 1'b0;
    while (pending_grants != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_round_robin_slice_scheduler OK");
    end else begin
      $display("tb_round_robin_slice_scheduler NOT OK");
    end
    $finish;
  end

endmodule
